@@ hdl/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the time window schedule select
// Word layouts, table geometry and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

   // table geometry
   localparam int PROGRAMS = 8;
   localparam int IDX_W    = $clog2(PROGRAMS);
   localparam int CNT_W    = 4;

   // field widths
   localparam int HHMM_W   = 14;
   localparam int MIN_W    = 11;
   localparam int DAY_W    = 16;
   localparam int HOUR_W   = 8;

   // divide by 100 through a reciprocal, exact for every 14-bit value
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] HHMM_RECIP = 13'd5243;

   // time limits
   localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 8'd24;
   localparam logic [6:0]        MINS_PER_HOUR = 7'd60;
   localparam logic [6:0]        HHMM_SCALE    = 7'd100;
   localparam logic [2:0]        WEEKDAY_LAST  = 3'd7;

   // function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [2:0]        slot;
      logic              enabled;
      logic [6:0]        day_bits;
      logic [HHMM_W-1:0] open_hhmm;
      logic [HHMM_W-1:0] close_hhmm;
      logic [DAY_W-1:0]  prior_run;
      logic              clock_ok;
      logic [2:0]        weekday;
      logic [MIN_W-1:0]  now_minute;
      logic [DAY_W-1:0]  today_code;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] program_number;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic store;
      logic advance;
      logic respond;
      logic found;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_write;
      logic scan_stop;
      logic due;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/tws_ctrl.sv @@
// ----------------------------------------------------------------------------
// tws_ctrl: sequencing controller
// Decodes an accepted word, runs the entry store or the one entry
// per cycle table scan, and raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_valid,
   output tws_pkg::cmd_type         cmd,
   input  wire tws_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.req_write ? ST_WRITE : ST_SCAN;
            end
         end
         ST_WRITE: begin
            cmd.store   = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_stop) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.due) begin
               cmd.respond = 1'b1;
               cmd.found   = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and strobe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/tws_dpath.sv @@
// ----------------------------------------------------------------------------
// tws_dpath: schedule table datapath
// Holds the count register, the request capture, HHMM to minute conversion,
// the entry table, the scan index, the due test and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tws_pkg::req_type     req,
   input  wire logic                 csr_write,
   input  wire logic [tws_pkg::CNT_W-1:0] csr_data,
   input  wire tws_pkg::cmd_type     cmd,
   output tws_pkg::status_type       status,
   output tws_pkg::rsp_type          rsp
);

   typedef struct packed {
      logic [6:0]                 day_bits;
      logic [tws_pkg::MIN_W-1:0]  start_min;
      logic [tws_pkg::MIN_W-1:0]  end_min;
      logic                       end_zero;
      logic [tws_pkg::DAY_W-1:0]  prior_run;
   } entry_type;

   localparam int PROD_W = tws_pkg::HHMM_W + tws_pkg::RECIP_W;

   logic [tws_pkg::CNT_W-1:0]  count_ff;
   tws_pkg::req_type           req_ff;
   logic [tws_pkg::HOUR_W-1:0] start_hour_ff, end_hour_ff;
   logic [PROD_W-1:0]          start_prod, end_prod;
   entry_type                  table_ff [tws_pkg::PROGRAMS];
   logic [tws_pkg::PROGRAMS-1:0] enabled_ff;
   logic [tws_pkg::CNT_W-1:0]  idx_ff;
   tws_pkg::rsp_type           rsp_ff;

   logic [tws_pkg::MIN_W-1:0]  start_min, end_min;
   logic [tws_pkg::CNT_W-1:0]  count_sat;
   entry_type                  cur;
   logic                       cur_enabled;
   logic                       day_ok, window_ok, open_end;
   logic [tws_pkg::MIN_W-1:0]  minute;
   logic [2:0]                 wd_bit;

   // convert a decimal HHMM word to minutes, invalid values give zero
   function automatic logic [tws_pkg::MIN_W-1:0] to_minutes(
      input logic [tws_pkg::HHMM_W-1:0] hhmm,
      input logic [tws_pkg::HOUR_W-1:0] hour
   );
      logic [tws_pkg::HHMM_W-1:0] rem;
      logic [tws_pkg::HHMM_W-1:0] hour_x100;
      logic [tws_pkg::MIN_W-1:0]  total;
      hour_x100 = tws_pkg::HHMM_W'(hour) * tws_pkg::HHMM_W'(tws_pkg::HHMM_SCALE);
      rem       = hhmm - hour_x100;
      total     = tws_pkg::MIN_W'(hour[4:0]) * tws_pkg::MIN_W'(tws_pkg::MINS_PER_HOUR)
                  + tws_pkg::MIN_W'(rem[5:0]);
      if (hour >= tws_pkg::HOURS_PER_DAY ||
          rem >= tws_pkg::HHMM_W'(tws_pkg::MINS_PER_HOUR)) begin
         total = '0;
      end
      return total;
   endfunction

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write) begin
         count_ff <= csr_data;
      end
   end

   // capture the word and take the hours by reciprocal multiply
   assign start_prod = PROD_W'(req.open_hhmm) * PROD_W'(tws_pkg::HHMM_RECIP);
   assign end_prod   = PROD_W'(req.close_hhmm) * PROD_W'(tws_pkg::HHMM_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff        <= req;
         start_hour_ff <= start_prod[tws_pkg::RECIP_SHIFT +: tws_pkg::HOUR_W];
         end_hour_ff   <= end_prod[tws_pkg::RECIP_SHIFT +: tws_pkg::HOUR_W];
      end
   end

   assign start_min = to_minutes(req_ff.open_hhmm, start_hour_ff);
   assign end_min   = to_minutes(req_ff.close_hhmm, end_hour_ff);

   // store one entry; every 3-bit slot lies inside the table
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         table_ff[req_ff.slot[tws_pkg::IDX_W-1:0]] <= '{
            day_bits:  req_ff.day_bits,
            start_min: start_min,
            end_min:   end_min,
            end_zero:  (req_ff.close_hhmm == '0),
            prior_run: req_ff.prior_run
         };
      end
   end

   // entry enables clear at reset so the whole table reads as disabled
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= '0;
      end else if (cmd.store) begin
         enabled_ff[req_ff.slot[tws_pkg::IDX_W-1:0]] <= req_ff.enabled;
      end
   end

   // scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // saturate the searched count at the table size
   assign count_sat = (count_ff > tws_pkg::CNT_W'(tws_pkg::PROGRAMS))
                      ? tws_pkg::CNT_W'(tws_pkg::PROGRAMS) : count_ff;

   // due test on the entry under the index
   assign cur         = table_ff[idx_ff[tws_pkg::IDX_W-1:0]];
   assign cur_enabled = enabled_ff[idx_ff[tws_pkg::IDX_W-1:0]];
   assign minute      = req_ff.now_minute;
   assign wd_bit      = req_ff.weekday - 3'd1;
   assign day_ok      = (req_ff.weekday != 3'd0) &&
                        (req_ff.weekday <= tws_pkg::WEEKDAY_LAST) &&
                        cur.day_bits[wd_bit];
   assign open_end    = cur.end_zero || (cur.start_min == cur.end_min);

   always_comb begin
      if (open_end) begin
         window_ok = (minute >= cur.start_min);
      end else if (cur.start_min < cur.end_min) begin
         window_ok = (minute >= cur.start_min) && (minute <= cur.end_min);
      end else begin
         window_ok = (minute >= cur.start_min) || (minute <= cur.end_min);
      end
   end

   assign status.req_write = (req.func == tws_pkg::FUNC_WRITE);
   assign status.scan_stop = !req_ff.clock_ok || (idx_ff >= count_sat);
   assign status.due       = cur_enabled && day_ok && window_ok &&
                             (cur.prior_run != req_ff.today_code);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.found          <= cmd.found;
         rsp_ff.program_number <= cmd.found ? idx_ff + 1'b1 : '0;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/time_window_schedule_select.sv @@
// ----------------------------------------------------------------------------
// time_window_schedule_select: top level of the schedule selector
// Joins the controller and the datapath and exposes the command, result and
// configuration ports.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word while busy is low. A write word
// (func 0) is stored in the write state, and the result strobe is registered
// from that state; an evaluate word walks the table one entry per cycle and
// gives its result, registered likewise, once the scan finds a due entry,
// reaches the saturated count or sees clock_ok low. rsp_valid is high for
// exactly one cycle and the receiver cannot stall it, so capture the result
// in that cycle. A new word may be started in the cycle the strobe shows.
// The count register may be written at any time through the csr channel,
// which is always ready; write it only while no word is in flight.
`default_nettype none

module time_window_schedule_select (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire tws_pkg::req_type        req_data,
   output logic                         rsp_valid,
   output tws_pkg::rsp_type             rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [tws_pkg::CNT_W-1:0] csr_data
);

   tws_pkg::cmd_type    cmd;
   tws_pkg::status_type status;

   // the count register is a plain flop, always ready
   assign csr_ready = 1'b1;

   tws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   tws_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_data)
   );

endmodule

`default_nettype wire

@@ hdl/tws_checker.sv @@
// ----------------------------------------------------------------------------
// tws_checker: port-level checks for the schedule selector
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire tws_pkg::rsp_type rsp_data
);

   // an accepted word holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without work in flight");

   // finishing work always yields a result
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("work ended without a result");

   // found and program number agree
   a_found_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.found == (rsp_data.program_number != '0)))
      else $error("found flag and program number disagree");

   // program number stays within the table
   a_num_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.program_number <= tws_pkg::CNT_W'(tws_pkg::PROGRAMS)))
      else $error("program number beyond table");

endmodule

bind time_window_schedule_select tws_checker u_tws_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for time_window_schedule_select
// Sends table writes and evaluate words with random gaps and checks each
// result strobe against a shadow copy of the schedule table and count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int   STALL_LIMIT   = 2000;
   localparam int   SETTLE_CYCLES = tws_pkg::PROGRAMS + 4;
   localparam int   QUIET_NEEDED  = 2;
   localparam int   RANDOM_WORDS  = 1430;
   localparam int   MAX_REPORTS   = 10;

   typedef enum logic [1:0] {OP_WORD, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      tws_pkg::req_type          word;
      logic [tws_pkg::CNT_W-1:0] count;
   } pending_op_type;

   typedef struct packed {
      logic                       enabled;
      logic [6:0]                 day_bits;
      logic [tws_pkg::HHMM_W-1:0] open_hhmm;
      logic [tws_pkg::HHMM_W-1:0] close_hhmm;
      logic [tws_pkg::DAY_W-1:0]  prior_run;
   } sched_entry_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   tws_pkg::req_type          req_data  = '0;
   logic                      rsp_valid;
   tws_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [tws_pkg::CNT_W-1:0] csr_data  = '0;

   // shadow state of the block
   sched_entry_type           shadow_table [tws_pkg::PROGRAMS];
   logic [tws_pkg::CNT_W-1:0] shadow_count;

   pending_op_type            pending_ops [$];
   tws_pkg::rsp_type          expected_rsp [$];
   logic [tws_pkg::DAY_W-1:0] day_pool [4];

   int unsigned gap_left     = 0;
   int unsigned burst_left   = 0;
   int unsigned quiet_cycles = 0;
   int          mismatches   = 0;
   int          words_sent   = 0;
   int          writes_sent  = 0;
   int          csr_writes   = 0;
   int          drains       = 0;
   int          hits         = 0;

   time_window_schedule_select dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // schedule predictor
   // ------------------------------------------------------------------

   // convert decimal HHMM to minutes, invalid times go to minute zero
   function automatic int unsigned hhmm_to_minute(logic [tws_pkg::HHMM_W-1:0] hhmm);
      int unsigned hours;
      int unsigned mins;
      hours = hhmm / tws_pkg::HHMM_SCALE;
      mins  = hhmm % tws_pkg::HHMM_SCALE;
      if (hours >= tws_pkg::HOURS_PER_DAY || mins >= tws_pkg::MINS_PER_HOUR) return 0;
      return hours * tws_pkg::MINS_PER_HOUR + mins;
   endfunction

   function automatic bit minute_in_window(int unsigned minute,
                                           logic [tws_pkg::HHMM_W-1:0] s_hhmm,
                                           logic [tws_pkg::HHMM_W-1:0] e_hhmm);
      int unsigned s;
      int unsigned e;
      s = hhmm_to_minute(s_hhmm);
      e = hhmm_to_minute(e_hhmm);
      // open-ended window
      if (e_hhmm == 0 || s == e) return minute >= s;
      if (s < e) return minute >= s && minute <= e;
      // window wraps past midnight
      return minute >= s || minute <= e;
   endfunction

   function automatic bit entry_is_due(sched_entry_type ent, tws_pkg::req_type word);
      if (!ent.enabled) return 0;
      if (word.weekday < 1 || word.weekday > tws_pkg::WEEKDAY_LAST) return 0;
      if (!ent.day_bits[word.weekday - 1]) return 0;
      if (!minute_in_window(word.now_minute, ent.open_hhmm, ent.close_hhmm))
         return 0;
      return ent.prior_run != word.today_code;
   endfunction

   // apply one word to the shadow table and return its result
   function automatic tws_pkg::rsp_type predict_schedule(tws_pkg::req_type word);
      tws_pkg::rsp_type res;
      int unsigned      limit;
      int unsigned      i;
      res = '0;
      if (word.func == tws_pkg::FUNC_WRITE) begin
         if (word.slot < tws_pkg::PROGRAMS)
            shadow_table[word.slot] = {word.enabled, word.day_bits,
                                       word.open_hhmm, word.close_hhmm,
                                       word.prior_run};
         return res;
      end
      if (!word.clock_ok) return res;
      // saturate the count at the table size
      limit = (shadow_count > tws_pkg::PROGRAMS) ? tws_pkg::PROGRAMS : shadow_count;
      for (i = 0; i < limit; i++) begin
         if (entry_is_due(shadow_table[i], word)) begin
            res.found          = 1'b1;
            res.program_number = tws_pkg::CNT_W'(i + 1);
            return res;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------

   function automatic tws_pkg::req_type random_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(tws_pkg::req_type)-1:0];
   endfunction

   function automatic logic [tws_pkg::HHMM_W-1:0] random_hhmm();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return tws_pkg::HHMM_W'($urandom);
         2: return tws_pkg::HHMM_W'($urandom_range(0, 23) * tws_pkg::HHMM_SCALE
                                    + $urandom_range(60, 99));
         default: return tws_pkg::HHMM_W'($urandom_range(0, 23) * tws_pkg::HHMM_SCALE
                                          + $urandom_range(0, 59));
      endcase
   endfunction

   // mostly reuse a few dates so that last-run matches happen
   function automatic logic [tws_pkg::DAY_W-1:0] random_day();
      if ($urandom_range(0, 4) == 0) return tws_pkg::DAY_W'($urandom);
      return day_pool[$urandom_range(0, 3)];
   endfunction

   function automatic tws_pkg::req_type make_write(int slot, bit en, logic [6:0] mask,
                                                   int s_hhmm, int e_hhmm, int last_day);
      tws_pkg::req_type w;
      w            = random_word();
      w.func       = tws_pkg::FUNC_WRITE;
      w.slot       = 3'(slot);
      w.enabled    = en;
      w.day_bits   = mask;
      w.open_hhmm  = tws_pkg::HHMM_W'(s_hhmm);
      w.close_hhmm = tws_pkg::HHMM_W'(e_hhmm);
      w.prior_run  = tws_pkg::DAY_W'(last_day);
      return w;
   endfunction

   function automatic tws_pkg::req_type make_eval(bit ready, int wday, int minute,
                                                  int today);
      tws_pkg::req_type w;
      w            = random_word();
      w.func       = tws_pkg::FUNC_EVAL;
      w.clock_ok   = ready;
      w.weekday    = 3'(wday);
      w.now_minute = tws_pkg::MIN_W'(minute);
      w.today_code = tws_pkg::DAY_W'(today);
      return w;
   endfunction

   function automatic tws_pkg::req_type random_write();
      tws_pkg::req_type w;
      w            = random_word();
      w.func       = tws_pkg::FUNC_WRITE;
      w.enabled    = ($urandom_range(0, 4) != 0);
      w.day_bits   = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom | $urandom);
      w.open_hhmm  = random_hhmm();
      w.close_hhmm = ($urandom_range(0, 7) == 0) ? w.open_hhmm : random_hhmm();
      w.prior_run  = random_day();
      return w;
   endfunction

   function automatic tws_pkg::req_type random_eval();
      tws_pkg::req_type w;
      w            = random_word();
      w.func       = tws_pkg::FUNC_EVAL;
      w.clock_ok   = ($urandom_range(0, 9) != 0);
      w.weekday    = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 7));
      w.now_minute = ($urandom_range(0, 15) == 0) ? tws_pkg::MIN_W'($urandom)
                                                  : tws_pkg::MIN_W'($urandom_range(0, 1439));
      w.today_code = random_day();
      return w;
   endfunction

   task automatic push_word(tws_pkg::req_type w);
      pending_ops.push_back('{kind: OP_WORD, word: w, count: '0});
   endtask

   task automatic push_csr(logic [tws_pkg::CNT_W-1:0] value);
      pending_ops.push_back('{kind: OP_CSR, word: '0, count: value});
   endtask

   task automatic push_drain();
      pending_ops.push_back('{kind: OP_DRAIN, word: '0, count: '0});
   endtask

   // pick the idle gap after a word or count write: mostly short, a few long, some bursts
   function automatic int unsigned next_gap();
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_failure(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      pending_op_type op;
      bit             word_taken;
      bit             chan_free;
      word_taken = start && !busy;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         // predict the word taken at this edge
         if (word_taken) begin
            expected_rsp.push_back(predict_schedule(req_data));
            words_sent++;
            if (req_data.func == tws_pkg::FUNC_WRITE) writes_sent++;
         end
         if (csr_valid && csr_ready) begin
            shadow_count = csr_data;
            csr_writes++;
         end
         // track how long the block has had nothing in flight
         if (expected_rsp.size() == 0 && !start) quiet_cycles++;
         else quiet_cycles = 0;

         chan_free = !(start && busy) && !(csr_valid && !csr_ready);
         if (chan_free) begin
            if (gap_left > 0) begin
               gap_left--;
               start     <= 1'b0;
               csr_valid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
               start     <= 1'b0;
               csr_valid <= 1'b0;
            end else begin
               op = pending_ops[0];
               case (op.kind)
                  OP_WORD: begin
                     start     <= 1'b1;
                     csr_valid <= 1'b0;
                     req_data  <= op.word;
                     void'(pending_ops.pop_front());
                     gap_left = next_gap();
                  end
                  OP_CSR: begin
                     start <= 1'b0;
                     // write the count only once the block is idle
                     if (quiet_cycles >= QUIET_NEEDED) begin
                        csr_valid <= 1'b1;
                        csr_data  <= op.count;
                        void'(pending_ops.pop_front());
                        gap_left = next_gap();
                     end else begin
                        csr_valid <= 1'b0;
                     end
                  end
                  default: begin
                     // hold off until every result is back
                     start     <= 1'b0;
                     csr_valid <= 1'b0;
                     if (expected_rsp.size() == 0) begin
                        void'(pending_ops.pop_front());
                        drains++;
                     end
                  end
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      tws_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_failure($sformatf("result found=%0b number=%0d with no word outstanding",
                                     rsp_data.found, rsp_data.program_number));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.found !== want.found)
               report_failure($sformatf("found expected %0b, got %0b",
                                        want.found, rsp_data.found));
            if (rsp_data.program_number !== want.program_number)
               report_failure($sformatf("program_number expected %0d, got %0d",
                                        want.program_number, rsp_data.program_number));
         end
         if (rsp_data.found === 1'b1) hits++;
      end
   end

   // ------------------------------------------------------------------
   // watchdog: end the run if no handshake happens for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) stalled = 0;
         else stalled++;
      end
      $display("Timeout: %0d cycles without a handshake, %0d results outstanding",
               STALL_LIMIT, expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      int i;
      int p;
      int j;
      int words;
      int phase_len;

      // shadow state after reset
      for (i = 0; i < tws_pkg::PROGRAMS; i++) shadow_table[i] = '0;
      shadow_count = '0;
      for (i = 0; i < 4; i++) day_pool[i] = tws_pkg::DAY_W'($urandom);

      // directed: window shapes, invalid times, weekday and day checks
      push_csr(tws_pkg::CNT_W'(tws_pkg::PROGRAMS));
      push_word(make_write(0, 1, 7'h7F, 800, 1000, 0));
      push_word(make_write(1, 1, 7'h01, 2200, 600, 16'hFFFF));
      push_word(make_write(2, 1, 7'h7F, 1200, 0, 100));
      push_word(make_write(3, 1, 7'h7F, 9999, 9999, 5));
      push_word(make_write(4, 1, 7'h40, 1230, 1230, 0));
      push_word(make_write(7, 0, 7'h7F, 0, 0, 0));
      push_word(make_eval(0, 1, 540, 200));
      push_word(make_eval(1, 0, 540, 200));
      push_word(make_eval(1, 1, 540, 200));
      push_word(make_eval(1, 1, 1439, 200));
      push_word(make_eval(1, 2, 30, 200));
      push_word(make_eval(1, 2, 30, 5));
      push_word(make_eval(1, 7, 2047, 16'hFFFF));
      push_word(make_eval(1, 7, 750, 100));
      push_csr('0);
      push_word(make_eval(1, 1, 540, 200));
      push_drain();
      push_csr('1);
      push_word(make_write(7, 1, 7'h7F, 0, 2359, 0));
      push_word(make_eval(1, 2, 30, 5));
      push_csr(tws_pkg::CNT_W'(1));
      push_word(make_eval(1, 1, 540, 200));
      push_word(make_eval(1, 1, 1439, 200));

      // random phases, each under its own count setting
      p = 0;
      words = 0;
      while (words < RANDOM_WORDS) begin
         case (p)
            0:       push_csr(tws_pkg::CNT_W'(tws_pkg::PROGRAMS));
            1:       push_csr('1);
            2:       push_csr('0);
            3:       push_csr(tws_pkg::CNT_W'(1));
            default: push_csr(tws_pkg::CNT_W'($urandom_range(2, 15)));
         endcase
         phase_len = $urandom_range(60, 200);
         for (j = 0; j < phase_len && words < RANDOM_WORDS; j++) begin
            if ($urandom_range(0, 79) == 0) push_drain();
            if ($urandom_range(0, 9) < 3) push_word(random_write());
            else push_word(random_eval());
            words++;
         end
         p++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // drain everything, then let the block settle
      while (pending_ops.size() != 0 || start || csr_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d table writes, %0d evaluates), %0d count writes, %0d drains",
               words_sent, writes_sent, words_sent - writes_sent, csr_writes, drains);
      $display("%0d evaluates selected an entry, %0d failures counted", hits, mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
